@@ hw/rtl/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and tables of the differential drive odometry block
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int IDX_W   = $clog2(CORDIC_ITERATIONS);
    localparam int NUM_W   = 34;      // divider dividend width
    localparam int DEN_W   = 16;      // divider divisor width
    localparam int CNT_W   = 6;       // divider step counter
    localparam int VEC_W   = 34;      // cordic x / y width, Q30 plus headroom
    localparam int ANG_W   = 34;      // cordic residual angle width
    localparam int DC_W    = 26;      // signed distance, Q10.16
    localparam int PRD_W   = DC_W + VEC_W;
    localparam int SUM_W   = PRD_W + 1;

    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);
    localparam logic [19:0]             HEAD_SCALE  = 20'd683565;
    localparam logic [30:0]             DIST_RECIP  = 31'd1099511628;  // ceil(2^37 / 125)
    localparam int                      DIST_SHIFT  = 37;
    localparam logic signed [ANG_W-1:0] QUARTER     = ANG_W'(1073741824);

    typedef enum logic {
        OP_STEP = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_TRACK_WIDTH   = 2'd0,
        REG_START_X       = 2'd1,
        REG_START_Y       = 2'd2,
        REG_START_HEADING = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_HMUL,
        S_DH_START,
        S_DH_WAIT,
        S_CORDIC,
        S_MUL_X,
        S_MUL_Y,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic prod;
        logic hmul;
        logic div_start;
        logic take_dc;
        logic cordic_step;
        logic mul_x;
        logic mul_y;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic cordic_last;
        logic is_load;
    } t_sts;

    function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = ANG_W'(536870912);
            5'd1:  v = ANG_W'(316933406);
            5'd2:  v = ANG_W'(167458907);
            5'd3:  v = ANG_W'(85004756);
            5'd4:  v = ANG_W'(42667331);
            5'd5:  v = ANG_W'(21354465);
            5'd6:  v = ANG_W'(10679838);
            5'd7:  v = ANG_W'(5340245);
            5'd8:  v = ANG_W'(2670163);
            5'd9:  v = ANG_W'(1335087);
            5'd10: v = ANG_W'(667544);
            5'd11: v = ANG_W'(333772);
            5'd12: v = ANG_W'(166886);
            5'd13: v = ANG_W'(83443);
            5'd14: v = ANG_W'(41722);
            5'd15: v = ANG_W'(20861);
            5'd16: v = ANG_W'(10430);
            5'd17: v = ANG_W'(5215);
            5'd18: v = ANG_W'(2608);
            5'd19: v = ANG_W'(1304);
            5'd20: v = ANG_W'(652);
            5'd21: v = ANG_W'(326);
            5'd22: v = ANG_W'(163);
            5'd23: v = ANG_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [31:0] r;
        if (v > SUM_W'(64'sd2147483647)) begin
            r = 32'h7fff_ffff;
        end else if (v < -SUM_W'(64'sd2147483648)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/odo_div.sv @@
// ----------------------------------------------------------------------------
// odo_div
// serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module odo_div
    import odo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_busy,
    output logic             o_done
);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

@@ hw/rtl/odo_dp.sv @@
// ----------------------------------------------------------------------------
// odo_dp
// odometry datapath: products, divider, cordic rotator and pose registers
// ----------------------------------------------------------------------------
module odo_dp
    import odo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_op,
    input  logic signed [15:0] i_left_velocity,
    input  logic signed [15:0] i_right_velocity,
    input  logic [9:0]         i_step_ms,
    input  logic [15:0]        i_track_width,
    input  logic [31:0]        i_start_x,
    input  logic [31:0]        i_start_y,
    input  logic [15:0]        i_start_heading,
    output logic [31:0]        o_pos_x,
    output logic [31:0]        o_pos_y,
    output logic [15:0]        o_pos_heading
);

    logic                    r_op;
    logic signed [15:0]      r_l;
    logic signed [15:0]      r_r;
    logic [9:0]              r_ms;
    logic [26:0]             r_smag;
    logic                    r_sneg;
    logic [26:0]             r_dmag;
    logic                    r_dneg;
    logic [47:0]             r_hnum;
    logic [61:0]             r_dq;
    logic signed [DC_W-1:0]  r_dc;
    logic signed [VEC_W-1:0] r_cx;
    logic signed [VEC_W-1:0] r_cy;
    logic signed [ANG_W-1:0] r_cz;
    logic                    r_flip;
    logic [IDX_W-1:0]        r_idx;
    logic signed [PRD_W-1:0] r_px;
    logic signed [PRD_W-1:0] r_py;
    logic [31:0]             r_pose_x;
    logic [31:0]             r_pose_y;
    logic [15:0]             r_pose_h;

    logic signed [16:0]      sum_v;
    logic signed [16:0]      dif_v;
    logic signed [27:0]      sprod;
    logic signed [27:0]      dprod;
    logic [15:0]             tw_eff;
    logic [30:0]             dist_m;
    logic [61:0]             dist_p;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic [NUM_W-1:0]        div_quo;
    logic                    div_busy;
    logic                    div_done;
    logic signed [31:0]      ang_a;
    logic signed [31:0]      ang_f;
    logic                    need_flip;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [ANG_W-1:0] atan_v;
    logic signed [VEC_W-1:0] cos_v;
    logic signed [VEC_W-1:0] sin_v;
    logic signed [PRD_W-1:0] dx;
    logic signed [PRD_W-1:0] dy;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;
    logic [15:0]             dh;

    assign sum_v  = 17'(r_l) + 17'(r_r);
    assign dif_v  = 17'(r_r) - 17'(r_l);
    assign sprod  = sum_v * $signed({1'b0, r_ms});
    assign dprod  = dif_v * $signed({1'b0, r_ms});
    assign tw_eff = (i_track_width == 16'd0) ? 16'd1 : i_track_width;

    // distance: (128 s + 500) / 1000 equals (16 s + 62) / 125, done as a
    // reciprocal multiply that is exact over the whole dividend range
    assign dist_m = {r_smag, 4'd0} + 31'd62;
    assign dist_p = 62'(dist_m) * 62'(DIST_RECIP);

    // heading divides by the track width after the 65536 factor has been
    // taken out as a shift
    assign div_num = NUM_W'(r_hnum[47:16]);
    assign div_den = tw_eff;

    odo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_busy  (div_busy),
        .o_done  (div_done)
    );

    // cordic start angle folded into the right half plane
    assign ang_a     = $signed({r_pose_h, 16'd0});
    assign need_flip = (ang_a > 32'sd1073741824) || (ang_a < -32'sd1073741824);
    assign ang_f     = ang_a - 32'sh8000_0000;
    assign xs        = r_cx >>> r_idx;
    assign ys        = r_cy >>> r_idx;
    assign atan_v    = atan_lookup(5'(r_idx));
    assign cos_v     = r_flip ? -r_cx : r_cx;
    assign sin_v     = r_flip ? -r_cy : r_cy;

    assign dx = (r_px + PRD_W'(64'sd536870912)) >>> 30;
    assign dy = (r_py + PRD_W'(64'sd536870912)) >>> 30;
    assign nx = SUM_W'($signed(r_pose_x)) + SUM_W'(dx);
    assign ny = SUM_W'($signed(r_pose_y)) + SUM_W'(dy);
    assign dh = r_dneg ? 16'(-div_quo[15:0]) : div_quo[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_l  <= i_left_velocity;
            r_r  <= i_right_velocity;
            r_ms <= i_step_ms;
        end
        if (i_cmd.prod) begin
            r_smag <= sprod[27] ? 27'(-sprod) : sprod[26:0];
            r_sneg <= sprod[27];
            r_dmag <= dprod[27] ? 27'(-dprod) : dprod[26:0];
            r_dneg <= dprod[27];
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= need_flip ? ANG_W'(ang_f) : ANG_W'(ang_a);
            r_flip <= need_flip;
            r_idx  <= '0;
        end
        if (i_cmd.hmul) begin
            r_hnum <= 48'(r_dmag) * 48'(HEAD_SCALE) + {17'd0, tw_eff, 15'd0};
            r_dq   <= dist_p;
        end
        if (i_cmd.take_dc) begin
            r_dc <= r_sneg ? -$signed({1'b0, r_dq[61:DIST_SHIFT]})
                           :  $signed({1'b0, r_dq[61:DIST_SHIFT]});
        end
        if (i_cmd.cordic_step) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_v;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_v;
            end
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.mul_x) begin
            r_px <= r_dc * cos_v;
        end
        if (i_cmd.mul_y) begin
            r_py <= r_dc * sin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x <= '0;
            r_pose_y <= '0;
            r_pose_h <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == OP_LOAD) begin
                r_pose_x <= i_start_x;
                r_pose_y <= i_start_y;
                r_pose_h <= i_start_heading;
            end else begin
                r_pose_x <= sat32(nx);
                r_pose_y <= sat32(ny);
                r_pose_h <= r_pose_h + dh;
            end
        end
    end

    assign o_sts.div_busy    = div_busy;
    assign o_sts.div_done    = div_done;
    assign o_sts.cordic_last = (r_idx == IDX_W'(CORDIC_ITERATIONS - 1));
    assign o_sts.is_load     = i_cmd.capture ? (i_op == OP_LOAD) : (r_op == OP_LOAD);
    assign o_pos_x           = r_pose_x;
    assign o_pos_y           = r_pose_y;
    assign o_pos_heading     = r_pose_h;

endmodule

@@ hw/rtl/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// odo_ctrl
// sequencer of one odometry update and owner of the result valid flag
// ----------------------------------------------------------------------------
module odo_ctrl
    import odo_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.is_load ? S_COMMIT : S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_HMUL;
            end
            S_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state = S_DH_START;
            end
            S_DH_START: begin
                o_cmd.take_dc   = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DH_WAIT;
            end
            S_DH_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_last) begin
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/differential_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry
// robot pose tracker by euler integration of wheel speeds
// ----------------------------------------------------------------------------
// usage
//   slave stream: s_tuser selects the item kind (step or load), s_tdata carries
//   left and right wheel speed and the step time; one transaction per item
//   master stream: one transaction per item with the pose after that item
//   apb port: track width and start pose registers at byte addresses 0, 4, 8, 12
// processing
//   a load item skips the arithmetic and goes from acceptance to the commit state
//   a step item runs one 34-step serial division (heading by the track width),
//   CORDIC_ITERATIONS (16) cordic rotations and two multiplies; the distance
//   by 1000 is a reciprocal multiply
//   one item is in work at a time; s_tready is high only while idle
// reset
//   synchronous, active low; pose and start pose clear to zero, track width
//   resets to 4096 (16 inches), no result is pending
// stall
//   the pose register is the result register; a new item may be accepted while
//   a result waits, but its pose update is held until the waiting result is taken
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import odo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // left_velocity[15:0], right_velocity[31:16],
                                   // step_ms[41:32], zero[47:42]
    input  logic        s_tuser,   // op
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pos_x[31:0], pos_y[63:32], pos_heading[79:64]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_track_width;
    logic [31:0] r_start_x;
    logic [31:0] r_start_y;
    logic [15:0] r_start_heading;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] pos_heading;

    // register file, written in the apb access phase
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_width   <= 16'd4096;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TRACK_WIDTH:   r_track_width   <= pwdata[15:0];
                REG_START_X:       r_start_x       <= pwdata;
                REG_START_Y:       r_start_y       <= pwdata;
                REG_START_HEADING: r_start_heading <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TRACK_WIDTH:   prdata = {16'd0, r_track_width};
            REG_START_X:       prdata = r_start_x;
            REG_START_Y:       prdata = r_start_y;
            REG_START_HEADING: prdata = {16'd0, r_start_heading};
            default:           prdata = '0;
        endcase
    end

    // sequencer
    odo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and pose state
    odo_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (s_tuser),
        .i_left_velocity  ($signed(s_tdata[15:0])),
        .i_right_velocity ($signed(s_tdata[31:16])),
        .i_step_ms        (s_tdata[41:32]),
        .i_track_width    (r_track_width),
        .i_start_x        (r_start_x),
        .i_start_y        (r_start_y),
        .i_start_heading  (r_start_heading),
        .o_pos_x          (pos_x),
        .o_pos_y          (pos_y),
        .o_pos_heading    (pos_heading)
    );

    assign m_tdata = {pos_heading, pos_y, pos_x};

    // one item at a time: no second acceptance right after one
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // the pose only moves when the result slot is free
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("pose overwritten under a pending result");

    // every commit yields a result
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_tvalid)
        else $error("commit without result");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

endmodule

@@ test/odo_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// odo_checker
// watches the config port and both streams, keeps its own pose model and
// compares every result transaction with the oldest predicted pose
// ----------------------------------------------------------------------------
module odo_checker
    import odo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] h;
    } t_pose;

    localparam longint ATAN_TAB [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    logic [15:0] cfg_track;
    logic [31:0] cfg_sx, cfg_sy;
    logic [15:0] cfg_sh;
    t_pose       pose;
    t_pose       pose_q[$];

    function automatic longint round_div(input longint n, input longint d);
        longint q;
        q = ((n < 0 ? -n : n) + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // rotate the gain vector to the heading, folded into the right half plane
    task automatic sin_cos(input logic [15:0] hd, output longint c, output longint s);
        logic [31:0] a;
        longint z, vx, vy, xs, ys;
        bit flip;
        a = {hd, 16'h0};
        z = longint'($signed(a));
        flip = 0;
        vx = 652032874;
        vy = 0;
        if (z > 1073741824 || z < -1073741824) begin
            a = a - 32'h8000_0000;
            z = longint'($signed(a));
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0) begin
                vx -= ys; vy += xs; z -= ATAN_TAB[i];
            end else begin
                vx += ys; vy -= xs; z += ATAN_TAB[i];
            end
        end
        c = flip ? -vx : vx;
        s = flip ? -vy : vy;
    endtask

    task automatic advance_pose(input logic op, input logic [47:0] d);
        longint l, r, ms, tw, dc, c, s, dh;
        if (op == OP_LOAD) begin
            pose = '{cfg_sx, cfg_sy, cfg_sh};
        end else begin
            l  = longint'($signed(d[15:0]));
            r  = longint'($signed(d[31:16]));
            ms = longint'(d[41:32]);
            tw = (cfg_track == 0) ? 1 : longint'(cfg_track);
            dc = round_div((l + r) * ms * 128, 1000);
            sin_cos(pose.h, c, s);
            pose.x = clip32(longint'($signed(pose.x)) + ((dc * c + (64'sd1 <<< 29)) >>> 30));
            pose.y = clip32(longint'($signed(pose.y)) + ((dc * s + (64'sd1 <<< 29)) >>> 30));
            dh = round_div((r - l) * ms * 683565, tw * 65536);
            pose.h = pose.h + dh[15:0];
        end
        pose_q = {pose_q, pose};
    endtask

    always @(posedge i_clk) begin
        t_pose exp_p, got;
        if (!i_rst_n) begin
            cfg_track <= 16'd4096;
            cfg_sx    <= '0;
            cfg_sy    <= '0;
            cfg_sh    <= '0;
            pose      = '0;
            o_errors  <= 0;
        end else begin
            // result first: the queue may be empty until this edge's input is added
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[31:0];
                got.y = m_tdata[63:32];
                got.h = m_tdata[79:64];
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h h=%h", $time,
                             got.x, got.y, got.h);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_p = pose_q.pop_front();
                    if (got.x !== exp_p.x)
                        $display("%0t: pos_x expected %h actual %h", $time, exp_p.x, got.x);
                    if (got.y !== exp_p.y)
                        $display("%0t: pos_y expected %h actual %h", $time, exp_p.y, got.y);
                    if (got.h !== exp_p.h)
                        $display("%0t: pos_heading expected %h actual %h", $time,
                                 exp_p.h, got.h);
                    if (got !== exp_p) o_errors <= o_errors + 1;
                end
            end
            if (s_tvalid && s_tready) advance_pose(s_tuser, s_tdata);
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_TRACK_WIDTH:   cfg_track <= pwdata[15:0];
                    REG_START_X:       cfg_sx    <= pwdata;
                    REG_START_Y:       cfg_sy    <= pwdata;
                    REG_START_HEADING: cfg_sh    <= pwdata[15:0];
                endcase
            end
        end
        o_pending <= pose_q.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives step and load items and register writes into the odometry block
// with random gaps and back pressure; a checker module predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
    import odo_pkg::*;

    localparam int LIMIT = 2000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // left_velocity[15:0], right_velocity[31:16], step_ms[41:32]
    logic        s_tuser = 0;    // op
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;        // pos_x[31:0], pos_y[63:32], pos_heading[79:64]
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  errors, pending;
    int  cycles = 0;
    bit  no_idle = 0;   // stretch with neither side idling

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    differential_drive_odometry u_dut (.*);

    odo_checker u_chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .psel, .penable, .pwrite, .paddr,
        .pwdata, .pready, .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back pressure, changed at the falling edge
    always @(negedge i_clk)
        m_tready <= no_idle || ($urandom_range(99) >= 35);

    // register write: setup cycle then access cycle
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] v);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // one item transaction; valid stays high into the next item unless a gap is drawn
    task automatic send_item(input t_op op, input logic [15:0] l, input logic [15:0] r,
                             input logic [9:0] ms);
        if (!no_idle && $urandom_range(99) < 35) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid = 1;
        s_tuser  = op;
        s_tdata  = {6'b0, ms, r, l};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // drop valid, then wait until every predicted pose has come back
    task automatic drain();
        s_tvalid = 0;
        do @(posedge i_clk); while (pending != 0 || m_tvalid);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_step();
        logic [15:0] l, r;
        if ($urandom_range(3) == 0) begin
            l = 16'($urandom); r = 16'($urandom);     // full range
        end else begin
            l = 16'($signed($urandom_range(0, 8192)) - 4096);
            r = 16'(l + $signed($urandom_range(0, 2048)) - 1024);
        end
        send_item(OP_STEP, l, r, 10'($urandom_range(0, 1023)));
    endtask

    initial begin
        static logic [15:0] tw_set [6] = '{16'd256, 16'd65535, 16'd0, 16'd1, 16'd4096,
                                           16'd1000};
        static logic [15:0] hd_set [6] = '{16'h4000, 16'h4001, 16'h8000, 16'hC000,
                                           16'hBFFF, 16'h0};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // directed: velocity and time extremes at reset settings
        send_item(OP_STEP, 16'h7fff, 16'h7fff, 10'd1000);
        send_item(OP_STEP, 16'h8000, 16'h8000, 10'd1023);
        send_item(OP_STEP, 16'h8000, 16'h7fff, 10'd1000);
        send_item(OP_STEP, 16'h7fff, 16'h8000, 10'd1);
        send_item(OP_STEP, 16'h0100, 16'h0100, 10'd0);
        send_item(OP_STEP, 16'hffff, 16'h0001, 10'd1023);
        send_item(OP_LOAD, 16'hffff, 16'hffff, 10'h3ff);   // load ignores the other fields
        drain();

        // directed: saturation near both ends of x and y
        reg_write(REG_START_X, 32'h7fff_0000);
        reg_write(REG_START_Y, 32'h8000_0000);
        reg_write(REG_START_HEADING, 32'h0000_C000);
        send_item(OP_LOAD, '0, '0, '0);
        send_item(OP_STEP, 16'h7fff, 16'h7fff, 10'd1023);
        send_item(OP_STEP, 16'h7fff, 16'h7fff, 10'd1023);
        drain();
        reg_write(REG_START_HEADING, 32'h0000_0000);
        send_item(OP_LOAD, '0, '0, '0);
        send_item(OP_STEP, 16'h7fff, 16'h7fff, 10'd1023);
        drain();

        // directed: each track width extreme, zero width among them, with fold headings
        foreach (tw_set[i]) begin
            reg_write(REG_TRACK_WIDTH, 32'(tw_set[i]));
            reg_write(REG_START_HEADING, 32'(hd_set[i]));
            reg_write(REG_START_X, 32'h0);
            reg_write(REG_START_Y, 32'h0);
            send_item(OP_LOAD, '0, '0, '0);
            send_item(OP_STEP, 16'h7fff, 16'h8000, 10'd1023);
            drain();
        end

        // random phases, settings changed while idle
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 2) reg_write(REG_TRACK_WIDTH, ph ? 32'd65535 : 32'd256);
            else reg_write(REG_TRACK_WIDTH, 32'($urandom_range(256, 65535)));
            reg_write(REG_START_X, $urandom);
            reg_write(REG_START_Y, $urandom);
            reg_write(REG_START_HEADING, 32'(16'($urandom)));
            no_idle = (ph == 4);
            for (int n = 0; n < 130; n++) begin
                if ($urandom_range(9) == 0) send_item(OP_LOAD, 16'($urandom), 16'($urandom),
                                                      10'($urandom));
                else random_step();
            end
            no_idle = 0;
            drain();
        end

        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
